// ----- src/bss_pkg.sv -----
package bss_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [7:0]  MASTER_ID_RST      = 8'h44;
  localparam logic [7:0]  OWN_ID_RST         = 8'h25;
  localparam logic [5:0]  ACTIVE_SLOTS_RST   = 6'd16;
  localparam logic [5:0]  FRAME_SLOTS_RST    = 6'd48;
  localparam logic [11:0] LIFETIME_TICKS_RST = 12'd1807;
  localparam logic [15:0] TICK_COUNTS_RST    = 16'd2075;
  localparam logic [15:0] RESYNC_COUNTS_RST  = 16'd519;
  localparam logic [7:0]  BLINK_TICKS_RST    = 8'd90;

  // Saturation limits of the acquisition and gap counters, and the gap limit that restarts acquisition.
  localparam logic [5:0] IDS_MAX = 6'd63;
  localparam logic [1:0] GAP_MAX = 2'd3;
  localparam logic [1:0] GAP_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    REG_MASTER_ID      = 3'd0,
    REG_OWN_ID         = 3'd1,
    REG_ACTIVE_SLOTS   = 3'd2,
    REG_FRAME_SLOTS    = 3'd3,
    REG_LIFETIME_TICKS = 3'd4,
    REG_TICK_COUNTS    = 3'd5,
    REG_RESYNC_COUNTS  = 3'd6,
    REG_BLINK_TICKS    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  master_id;
    logic [7:0]  own_id;
    logic [5:0]  active_slots;
    logic [5:0]  frame_slots;
    logic [11:0] lifetime_ticks;
    logic [15:0] tick_counts;
    logic [15:0] resync_counts;
    logic [7:0]  blink_ticks;
  } cfg_t;

  typedef struct packed {
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_error;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       led_on;
    logic       locked;
  } res_t;

endpackage

// ----- src/bss_if.sv -----
interface bss_in_if;
  logic       valid;
  logic       ready;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       rx_error;

  modport source (output valid, output rx_valid, output rx_byte, output rx_error,
                  input ready);
  modport sink (input valid, input rx_valid, input rx_byte, input rx_error,
                output ready);
endinterface

interface bss_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       led_on;
  logic       locked;

  modport source (output valid, output tx_valid, output tx_byte, output led_on,
                  output locked, input ready);
  modport sink (input valid, input tx_valid, input tx_byte, input led_on,
                input locked, output ready);
endinterface

// ----- src/bss_cfg.sv -----
module bss_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bss_pkg::ADDR_W-1:0]  paddr,
  input  logic [bss_pkg::DATA_W-1:0]  pwdata,
  output logic [bss_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bss_pkg::cfg_t               cfg
);

  bss_pkg::cfg_t     cfg_r;
  bss_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = bss_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.master_id      <= bss_pkg::MASTER_ID_RST;
      cfg_r.own_id         <= bss_pkg::OWN_ID_RST;
      cfg_r.active_slots   <= bss_pkg::ACTIVE_SLOTS_RST;
      cfg_r.frame_slots    <= bss_pkg::FRAME_SLOTS_RST;
      cfg_r.lifetime_ticks <= bss_pkg::LIFETIME_TICKS_RST;
      cfg_r.tick_counts    <= bss_pkg::TICK_COUNTS_RST;
      cfg_r.resync_counts  <= bss_pkg::RESYNC_COUNTS_RST;
      cfg_r.blink_ticks    <= bss_pkg::BLINK_TICKS_RST;
    end else if (wr_en) begin
      case (idx)
        bss_pkg::REG_MASTER_ID:      cfg_r.master_id      <= pwdata[7:0];
        bss_pkg::REG_OWN_ID:         cfg_r.own_id         <= pwdata[7:0];
        bss_pkg::REG_ACTIVE_SLOTS:   cfg_r.active_slots   <= pwdata[5:0];
        bss_pkg::REG_FRAME_SLOTS:    cfg_r.frame_slots    <= pwdata[5:0];
        bss_pkg::REG_LIFETIME_TICKS: cfg_r.lifetime_ticks <= pwdata[11:0];
        bss_pkg::REG_TICK_COUNTS:    cfg_r.tick_counts    <= pwdata[15:0];
        bss_pkg::REG_RESYNC_COUNTS:  cfg_r.resync_counts  <= pwdata[15:0];
        bss_pkg::REG_BLINK_TICKS:    cfg_r.blink_ticks    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bss_pkg::REG_MASTER_ID:      prdata = {24'd0, cfg_r.master_id};
      bss_pkg::REG_OWN_ID:         prdata = {24'd0, cfg_r.own_id};
      bss_pkg::REG_ACTIVE_SLOTS:   prdata = {26'd0, cfg_r.active_slots};
      bss_pkg::REG_FRAME_SLOTS:    prdata = {26'd0, cfg_r.frame_slots};
      bss_pkg::REG_LIFETIME_TICKS: prdata = {20'd0, cfg_r.lifetime_ticks};
      bss_pkg::REG_TICK_COUNTS:    prdata = {16'd0, cfg_r.tick_counts};
      bss_pkg::REG_RESYNC_COUNTS:  prdata = {16'd0, cfg_r.resync_counts};
      bss_pkg::REG_BLINK_TICKS:    prdata = {24'd0, cfg_r.blink_ticks};
      default:                     prdata = '0;
    endcase
  end

endmodule

// ----- src/bss_engine.sv -----
module bss_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  bss_pkg::item_t item,
  input  bss_pkg::cfg_t  cfg,
  output bss_pkg::res_t  res
);

  logic        locked_r, locked_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  slot_r, slot_nxt;
  logic [5:0]  ids_r, ids_nxt;
  logic [1:0]  gap_r, gap_nxt;
  logic [11:0] life_r, life_nxt;
  logic [7:0]  blink_r, blink_nxt;
  logic        led_r, led_nxt;

  logic [5:0] act;
  logic [5:0] frame;
  logic       tick;
  logic       master;
  logic       tx;

  // Next state for one timer count, in the order tick, byte, loss, acquisition, blink.
  always_comb begin
    act    = (cfg.active_slots == 6'd0) ? 6'd1 : cfg.active_slots;
    frame  = (cfg.frame_slots == 6'd0) ? 6'd1 : cfg.frame_slots;
    tick   = (count_r <= 16'd1);
    master = item.rx_valid & ~item.rx_error & (item.rx_byte == cfg.master_id);
    tx     = 1'b0;

    locked_nxt = locked_r;
    count_nxt  = count_r;
    slot_nxt   = slot_r;
    ids_nxt    = ids_r;
    gap_nxt    = gap_r;
    life_nxt   = life_r;
    blink_nxt  = blink_r;
    led_nxt    = led_r;

    if (tick) begin
      count_nxt = cfg.tick_counts;
      blink_nxt = blink_r + 8'd1;
      if (gap_r < bss_pkg::GAP_MAX) begin
        gap_nxt = gap_r + 2'd1;
      end
      slot_nxt = slot_r + 8'd1;
      if (life_r != 12'd0) begin
        life_nxt = life_r - 12'd1;
      end
      if (locked_r) begin
        if (slot_nxt >= {2'b00, frame}) begin
          slot_nxt = 8'd0;
        end
        tx = (slot_nxt < {2'b00, act});
      end
    end else begin
      count_nxt = count_r - 16'd1;
    end

    if (master) begin
      if (locked_r) begin
        count_nxt = cfg.resync_counts;
        life_nxt  = cfg.lifetime_ticks;
      end else begin
        if (ids_r < bss_pkg::IDS_MAX) begin
          ids_nxt = ids_r + 6'd1;
        end
        gap_nxt = 2'd0;
      end
    end

    if (locked_r && life_nxt == 12'd0) begin
      locked_nxt = 1'b0;
      led_nxt    = 1'b0;
      ids_nxt    = 6'd0;
      gap_nxt    = 2'd0;
    end

    if (!locked_nxt) begin
      if (gap_nxt > bss_pkg::GAP_LIMIT) begin
        ids_nxt = 6'd0;
        gap_nxt = 2'd0;
      end
      if (ids_nxt >= act) begin
        count_nxt  = {1'b0, cfg.tick_counts[15:1]};
        slot_nxt   = {2'b00, frame - 6'd1};
        locked_nxt = 1'b1;
        life_nxt   = cfg.lifetime_ticks;
        ids_nxt    = 6'd0;
        led_nxt    = 1'b1;
      end
    end

    if (locked_nxt && blink_nxt > cfg.blink_ticks) begin
      led_nxt   = ~led_nxt;
      blink_nxt = 8'd0;
    end

    res.tx_valid = tx;
    res.tx_byte  = tx ? cfg.own_id : 8'd0;
    res.led_on   = led_nxt;
    res.locked   = locked_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r <= 1'b0;
      count_r  <= bss_pkg::TICK_COUNTS_RST;
      slot_r   <= 8'd0;
      ids_r    <= 6'd0;
      gap_r    <= 2'd0;
      life_r   <= 12'd0;
      blink_r  <= 8'd0;
      led_r    <= 1'b0;
    end else if (step) begin
      locked_r <= locked_nxt;
      count_r  <= count_nxt;
      slot_r   <= slot_nxt;
      ids_r    <= ids_nxt;
      gap_r    <= gap_nxt;
      life_r   <= life_nxt;
      blink_r  <= blink_nxt;
      led_r    <= led_nxt;
    end
  end

endmodule

// ----- src/beacon_slot_synchronizer_core.sv -----
// Slave beacon slot synchronizer.
// Each transaction on the in_ch channel is one prescaled timer count, optionally
// carrying a received byte and its error flag. Every accepted count produces
// exactly one transaction on out_ch with the transmit request, the byte to send,
// the LED level and the lock status after that count.
// Items pass through an input register and a result register; the state update
// for one count is combinational logic between them. An accepted count passes
// through both registers before its result is offered, and one count is accepted
// in every cycle as long as the result side takes its transactions.
// The result register sits between the two sides: a new count is taken while a
// finished result waits, and in_ch.ready drops only when both registers are full
// and out_ch.ready is low. A stalled result holds its value until taken.
// The APB-style port (psel/penable/pwrite, pready always high) holds eight
// registers at byte addresses 4*i; write them only while the block is idle.
// Synchronous active-low reset returns all registers to their defaults, clears the
// valid flags of both pipeline registers and leaves the beacon unlocked, LED off.
module beacon_slot_synchronizer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  bss_in_if.sink                      in_ch,
  bss_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bss_pkg::ADDR_W-1:0]  paddr,
  input  logic [bss_pkg::DATA_W-1:0]  pwdata,
  output logic [bss_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  bss_pkg::cfg_t  cfg;
  bss_pkg::item_t in_item_r;
  bss_pkg::res_t  res;
  bss_pkg::res_t  out_res_r;
  logic           in_vld_r, in_vld_nxt;
  logic           out_vld_r, out_vld_nxt;
  logic           in_accept;
  logic           step_fire;

  bss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held count is processed whenever the result register is free or drains.
  assign step_fire   = in_vld_r & (~out_vld_r | out_ch.ready);
  assign in_ch.ready = ~in_vld_r | step_fire;
  assign in_accept   = in_ch.valid & in_ch.ready;

  bss_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step_fire),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (step_fire) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (step_fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r.rx_valid <= in_ch.rx_valid;
      in_item_r.rx_byte  <= in_ch.rx_byte;
      in_item_r.rx_error <= in_ch.rx_error;
    end
    if (step_fire) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.tx_valid = out_res_r.tx_valid;
  assign out_ch.tx_byte  = out_res_r.tx_byte;
  assign out_ch.led_on   = out_res_r.led_on;
  assign out_ch.locked   = out_res_r.locked;

  // A held count that is not processed must still be held next cycle.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !step_fire |=> in_vld_r)
    else $error("held input count lost without being processed");

  // Every processed count leaves a result to deliver.
  a_res_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire |=> out_vld_r)
    else $error("processed count produced no result");

  // The LED is only ever lit while locked.
  a_led_locked: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.led_on |-> out_res_r.locked)
    else $error("LED on while unlocked");

  // Nothing but the own ID is ever sent.
  a_tx_own: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.tx_valid |-> out_res_r.tx_byte == cfg.own_id)
    else $error("transmitted byte differs from own ID");

endmodule

// ----- tb/tb_beacon_slot_synchronizer_core.sv -----
module tb_beacon_slot_synchronizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  // The receiver holds off this long once per request, so that the result
  // register and then the input register fill and in_ch.ready drops.
  localparam int HOLD_CYCLES   = 80;
  // Cycles allowed after the last result before registers are touched or the
  // run ends.
  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT_NS    = 3_000_000;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_COUNTS  = 140;

  logic                        clk;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [bss_pkg::ADDR_W-1:0]  paddr;
  logic [bss_pkg::DATA_W-1:0]  pwdata;
  logic [bss_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  bss_in_if  in_if ();
  bss_out_if out_if ();

  beacon_slot_synchronizer_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Free-running 100 MHz clock; the first rising edge falls at 5 ns.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the configuration registers, updated as each write lands.
  bss_pkg::cfg_t reg_shadow;

  // Beacon state as the testbench expects it to be after every accepted count.
  logic        is_locked;
  logic [15:0] counts_to_tick;
  logic [7:0]  slot_no;
  logic [5:0]  master_hits;
  logic [1:0]  ticks_since_id;
  logic [11:0] life_ticks;
  logic [7:0]  blink_cnt;
  logic        led_state;

  // Status reports owed by the block, oldest first.
  bss_pkg::res_t beacon_reports_due[$];
  int            mismatch_count = 0;

  // Sender pacing: counts go out in bursts, with idle gaps between them
  // while gaps_on is set.
  bit   gaps_on    = 1'b1;
  int   burst_left = 0;

  // Receiver pacing. hold_req is bumped by a test to ask for one long
  // hold-off; the receiver notices the change and counts it out itself.
  logic        rcv_ready = 1'b0;
  int          hold_req  = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic [15:0] rcv_cyc   = '0;

  assign out_if.ready = rcv_ready;

  // Returns the beacon to its power-up state, with registers at defaults.
  task automatic reset_beacon_model();
    reg_shadow.master_id      = bss_pkg::MASTER_ID_RST;
    reg_shadow.own_id         = bss_pkg::OWN_ID_RST;
    reg_shadow.active_slots   = bss_pkg::ACTIVE_SLOTS_RST;
    reg_shadow.frame_slots    = bss_pkg::FRAME_SLOTS_RST;
    reg_shadow.lifetime_ticks = bss_pkg::LIFETIME_TICKS_RST;
    reg_shadow.tick_counts    = bss_pkg::TICK_COUNTS_RST;
    reg_shadow.resync_counts  = bss_pkg::RESYNC_COUNTS_RST;
    reg_shadow.blink_ticks    = bss_pkg::BLINK_TICKS_RST;
    is_locked      = 1'b0;
    counts_to_tick = bss_pkg::TICK_COUNTS_RST;
    slot_no        = '0;
    master_hits    = '0;
    ticks_since_id = '0;
    life_ticks     = '0;
    blink_cnt      = '0;
    led_state      = 1'b0;
  endtask

  // Advances the expected beacon state by one timer count and returns the
  // status report that the count should produce. The order of the steps
  // matters: tick first, then the received byte, then lifetime expiry, then
  // acquisition, and the LED blink last.
  task automatic step_beacon(input bss_pkg::item_t cnt, output bss_pkg::res_t rep);
    int unsigned act;
    int unsigned frame;
    logic        sending;
    logic        from_master;
    // A slot register of zero behaves as one.
    act     = (reg_shadow.active_slots == 0) ? 1 : reg_shadow.active_slots;
    frame   = (reg_shadow.frame_slots == 0) ? 1 : reg_shadow.frame_slots;
    sending = 1'b0;

    // A counter at zero or one ticks and reloads, so with a tick period of
    // zero or one every count is a tick.
    if (counts_to_tick <= 16'd1) begin
      counts_to_tick = reg_shadow.tick_counts;
      blink_cnt      = blink_cnt + 8'd1;
      if (ticks_since_id < bss_pkg::GAP_MAX) begin
        ticks_since_id = ticks_since_id + 2'd1;
      end
      slot_no = slot_no + 8'd1;
      if (life_ticks != 0) begin
        life_ticks = life_ticks - 12'd1;
      end
      if (is_locked) begin
        if (slot_no >= frame) begin
          slot_no = '0;
        end
        if (slot_no < act) begin
          sending = 1'b1;
        end
      end
    end else begin
      counts_to_tick = counts_to_tick - 16'd1;
    end

    // Errored bytes and bytes from anyone else are ignored.
    from_master = cnt.rx_valid && !cnt.rx_error && cnt.rx_byte == reg_shadow.master_id;
    if (from_master) begin
      if (is_locked) begin
        counts_to_tick = reg_shadow.resync_counts;
        life_ticks     = reg_shadow.lifetime_ticks;
      end else begin
        if (master_hits < bss_pkg::IDS_MAX) begin
          master_hits = master_hits + 6'd1;
        end
        ticks_since_id = '0;
      end
    end

    if (is_locked && life_ticks == 0) begin
      is_locked      = 1'b0;
      led_state      = 1'b0;
      master_hits    = '0;
      ticks_since_id = '0;
    end

    if (!is_locked) begin
      // Too long a silence between two master IDs restarts acquisition.
      if (ticks_since_id > bss_pkg::GAP_LIMIT) begin
        master_hits    = '0;
        ticks_since_id = '0;
      end
      // Lock lands the beacon half a period into the last slot of the frame.
      if (master_hits >= act) begin
        counts_to_tick = reg_shadow.tick_counts >> 1;
        slot_no        = 8'(frame - 1);
        is_locked      = 1'b1;
        life_ticks     = reg_shadow.lifetime_ticks;
        master_hits    = '0;
        led_state      = 1'b1;
      end
    end

    if (is_locked && blink_cnt > reg_shadow.blink_ticks) begin
      led_state = ~led_state;
      blink_cnt = '0;
    end

    rep.tx_valid = sending;
    rep.tx_byte  = sending ? reg_shadow.own_id : 8'h00;
    rep.led_on   = led_state;
    rep.locked   = is_locked;
  endtask

  function automatic bss_pkg::item_t make_count(logic has_byte, logic [7:0] rx, logic err);
    bss_pkg::item_t cnt;
    cnt.rx_valid = has_byte;
    cnt.rx_byte  = rx;
    cnt.rx_error = err;
    return cnt;
  endfunction

  // One random timer count. master_pct sets how often a clean master ID
  // comes along; the rest is errored master IDs, stray bytes and plain
  // counts. master_pct must stay at or below 80.
  function automatic bss_pkg::item_t random_count(int master_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < master_pct) begin
      return make_count(1'b1, reg_shadow.master_id, 1'b0);
    end else if (roll < master_pct + 5) begin
      return make_count(1'b1, reg_shadow.master_id, 1'b1);
    end else if (roll < master_pct + 15) begin
      return make_count(1'b1, 8'($urandom), 1'($urandom));
    end else begin
      return make_count(1'b0, 8'($urandom), 1'($urandom));
    end
  endfunction

  // Offers one count on in_ch and waits for its transaction. valid is left
  // high afterwards so that back-to-back counts follow without a break; gaps
  // are only opened at the start of a new burst.
  task automatic send_count(input bss_pkg::item_t cnt);
    int            gap;
    bss_pkg::res_t rep;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left = burst_left - 1;
    in_if.valid    <= 1'b1;
    in_if.rx_valid <= cnt.rx_valid;
    in_if.rx_byte  <= cnt.rx_byte;
    in_if.rx_error <= cnt.rx_error;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    step_beacon(cnt, rep);
    beacon_reports_due.push_back(rep);
  endtask

  task automatic send_random_counts(int n, int master_pct);
    repeat (n) send_count(random_count(master_pct));
  endtask

  // Stops offering counts and waits until every owed report has arrived,
  // then lets the block settle.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (beacon_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then an idle phase with psel low so
  // that back-to-back writes never assign psel twice in one time step.
  task automatic write_reg(input bss_pkg::reg_idx_t idx,
                           input logic [bss_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      bss_pkg::REG_MASTER_ID:      reg_shadow.master_id      = value[7:0];
      bss_pkg::REG_OWN_ID:         reg_shadow.own_id         = value[7:0];
      bss_pkg::REG_ACTIVE_SLOTS:   reg_shadow.active_slots   = value[5:0];
      bss_pkg::REG_FRAME_SLOTS:    reg_shadow.frame_slots    = value[5:0];
      bss_pkg::REG_LIFETIME_TICKS: reg_shadow.lifetime_ticks = value[11:0];
      bss_pkg::REG_TICK_COUNTS:    reg_shadow.tick_counts    = value[15:0];
      bss_pkg::REG_RESYNC_COUNTS:  reg_shadow.resync_counts  = value[15:0];
      bss_pkg::REG_BLINK_TICKS:    reg_shadow.blink_ticks    = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Waits for the block to go idle and then rewrites every register.
  task automatic set_all_regs(logic [7:0] master, logic [7:0] own, logic [5:0] act,
                              logic [5:0] frame, logic [11:0] life, logic [15:0] tick,
                              logic [15:0] resync, logic [7:0] blink);
    drain_results();
    write_reg(bss_pkg::REG_MASTER_ID, bss_pkg::DATA_W'(master));
    write_reg(bss_pkg::REG_OWN_ID, bss_pkg::DATA_W'(own));
    write_reg(bss_pkg::REG_ACTIVE_SLOTS, bss_pkg::DATA_W'(act));
    write_reg(bss_pkg::REG_FRAME_SLOTS, bss_pkg::DATA_W'(frame));
    write_reg(bss_pkg::REG_LIFETIME_TICKS, bss_pkg::DATA_W'(life));
    write_reg(bss_pkg::REG_TICK_COUNTS, bss_pkg::DATA_W'(tick));
    write_reg(bss_pkg::REG_RESYNC_COUNTS, bss_pkg::DATA_W'(resync));
    write_reg(bss_pkg::REG_BLINK_TICKS, bss_pkg::DATA_W'(blink));
  endtask

  // With the reset configuration, bytes that must not count toward lock
  // come first: a master value with no byte flagged, an errored master ID
  // and two stray bytes. Then a full run of master IDs acquires lock.
  task automatic test_default_lock();
    send_count(make_count(1'b0, bss_pkg::MASTER_ID_RST, 1'b0));
    send_count(make_count(1'b1, bss_pkg::MASTER_ID_RST, 1'b1));
    send_count(make_count(1'b1, 8'h00, 1'b0));
    send_count(make_count(1'b1, 8'hFF, 1'b1));
    repeat (bss_pkg::ACTIVE_SLOTS_RST) begin
      send_count(make_count(1'b1, bss_pkg::MASTER_ID_RST, 1'b0));
    end
    send_count(make_count(1'b0, 8'h00, 1'b0));
  endtask

  // Every count-like register but blink_ticks at zero. A master ID while locked
  // then loads a zero lifetime and drops lock at once; one ID is enough for
  // lock, and lock is lost again on the very next count, which also sends in slot 0.
  task automatic test_zero_registers();
    set_all_regs(bss_pkg::MASTER_ID_RST, bss_pkg::OWN_ID_RST, 6'd0, 6'd0, 12'd0, 16'd0,
                 16'd0, bss_pkg::BLINK_TICKS_RST);
    send_count(make_count(1'b1, bss_pkg::MASTER_ID_RST, 1'b0));
    send_count(make_count(1'b0, 8'h00, 1'b0));
    send_count(make_count(1'b1, bss_pkg::MASTER_ID_RST, 1'b0));
    send_count(make_count(1'b0, 8'h00, 1'b0));
    send_count(make_count(1'b1, bss_pkg::MASTER_ID_RST, 1'b0));
  endtask

  // Largest frame and acquisition length with a tick every second count, so the
  // slot counter wraps at 63 while locked; then the longest periods, where no
  // reloaded period runs out within the phase.
  task automatic test_extreme_settings();
    set_all_regs(8'h00, 8'hFF, 6'd63, 6'd63, 12'd4095, 16'd2, 16'd1, 8'd255);
    // A plain count first, so that any lock left from before with a zero
    // lifetime is dropped rather than refreshed.
    send_count(make_count(1'b0, 8'h00, 1'b0));
    repeat (63) send_count(make_count(1'b1, 8'h00, 1'b0));
    send_random_counts(150, 20);
    set_all_regs(8'hFF, 8'h00, 6'd1, 6'd1, 12'd1, 16'hFFFF, 16'hFFFF, 8'd1);
    send_random_counts(20, 35);
  endtask

  // The receiver stalls for a long stretch while counts keep coming with
  // no gaps, so the block fills up and holds off its input.
  task automatic test_result_backpressure();
    set_all_regs(8'($urandom), 8'($urandom), 6'd2, 6'd5, 12'd6, 16'd3, 16'd2, 8'd2);
    gaps_on  = 1'b0;
    hold_req = hold_req + 1;
    send_random_counts(60, 35);
    gaps_on = 1'b1;
    drain_results();
  endtask

  // Phases with small random periods so that lock, slot wrap, resync, blink
  // and loss all happen many times; the master ID rate decides whether a
  // phase mostly holds lock, keeps losing it or never gets there.
  task automatic test_random_phases();
    int          master_pct;
    logic [5:0]  act;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      act = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(1, 20)) : 6'($urandom_range(1, 6));
      set_all_regs(8'($urandom), 8'($urandom), act, 6'($urandom_range(1, 12)),
                   12'($urandom_range(1, 40)), 16'($urandom_range(1, 8)),
                   16'($urandom_range(0, 8)), 8'($urandom_range(0, 8)));
      case ($urandom_range(0, 3))
        0:       master_pct = 70;
        1:       master_pct = 35;
        2:       master_pct = 12;
        default: master_pct = 2;
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      send_random_counts(PHASE_COUNTS, master_pct);
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: a long hold-off when asked, otherwise a pattern chosen by bits 9:8
  // of a free-running cycle counter among always ready, mostly ready, a fixed stall
  // pattern and a coin toss.
  always @(posedge clk) begin
    rcv_cyc = rcv_cyc + 16'd1;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rcv_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      rcv_ready <= 1'b0;
    end else begin
      case (rcv_cyc[9:8])
        2'd0:    rcv_ready <= 1'b1;
        2'd1:    rcv_ready <= ($urandom_range(0, 3) != 0);
        2'd2:    rcv_ready <= (rcv_cyc[2:0] != 3'd5) && (rcv_cyc[2:0] != 3'd6);
        default: rcv_ready <= 1'($urandom);
      endcase
    end
  end

  // Every result transaction is matched against the oldest owed report.
  always @(posedge clk) begin : check_result
    bss_pkg::res_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (beacon_reports_due.size() == 0) begin
        $error("result transaction with no count waiting for it");
        mismatch_count++;
      end else begin
        want = beacon_reports_due.pop_front();
        if (out_if.tx_valid !== want.tx_valid) begin
          $error("tx_valid: expected %0d, got %0d", want.tx_valid, out_if.tx_valid);
          mismatch_count++;
        end
        if (out_if.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected 0x%02h, got 0x%02h", want.tx_byte, out_if.tx_byte);
          mismatch_count++;
        end
        if (out_if.led_on !== want.led_on) begin
          $error("led_on: expected %0d, got %0d", want.led_on, out_if.led_on);
          mismatch_count++;
        end
        if (out_if.locked !== want.locked) begin
          $error("locked: expected %0d, got %0d", want.locked, out_if.locked);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_if.valid    = 1'b0;
    in_if.rx_valid = 1'b0;
    in_if.rx_byte  = '0;
    in_if.rx_error = 1'b0;
    reset_beacon_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_lock();
    test_zero_registers();
    test_extreme_settings();
    test_result_backpressure();
    test_random_phases();
    drain_results();

    if (mismatch_count == 0 && beacon_reports_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
